>>> design/usbreq_pkg.sv
// Shared types and constants for the USB endpoint-0 standard request handler.
// No dependencies; every other design file imports this package.
`default_nettype none

package usbreq_pkg;

	// Configuration register file
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 8;
	localparam logic [CFG_IDX_W-1:0] REG_DEV_DESC_LEN = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_CFG_DESC_LEN = 1'b1;
	localparam logic [7:0] DEV_DESC_LEN_RST = 8'd18;
	localparam logic [7:0] CFG_DESC_LEN_RST = 8'd32;

	// Item kinds
	localparam logic KIND_BUS_RESET = 1'b0;

	// Actions
	localparam logic [1:0] ACT_NONE   = 2'd0;
	localparam logic [1:0] ACT_STALL  = 2'd1;
	localparam logic [1:0] ACT_STATUS = 2'd2;
	localparam logic [1:0] ACT_DATA   = 2'd3;

	// Reply sources
	localparam logic [1:0] SRC_INLINE = 2'd0;
	localparam logic [1:0] SRC_DEV    = 2'd1;
	localparam logic [1:0] SRC_CFG    = 2'd2;

	// Bulk endpoint pair changes
	localparam logic [1:0] EPC_NONE    = 2'd0;
	localparam logic [1:0] EPC_ENABLE  = 2'd1;
	localparam logic [1:0] EPC_DISABLE = 2'd2;

	// Requests as {bRequest, bmRequestType}
	localparam logic [15:0] RQ_GET_STATUS     = 16'h0080;
	localparam logic [15:0] RQ_GET_STATUS_IF  = 16'h0081;
	localparam logic [15:0] RQ_GET_STATUS_EP  = 16'h0082;
	localparam logic [15:0] RQ_SET_ADDRESS    = 16'h0500;
	localparam logic [15:0] RQ_GET_DESCRIPTOR = 16'h0680;
	localparam logic [15:0] RQ_GET_CONFIG     = 16'h0880;
	localparam logic [15:0] RQ_SET_CONFIG     = 16'h0900;
	localparam logic [15:0] RQ_GET_INTERFACE  = 16'h0A81;
	localparam logic [15:0] RQ_SET_INTERFACE  = 16'h0B01;

	// Descriptor selectors and endpoint addresses
	localparam logic [15:0] DESC_DEVICE = 16'h0100;
	localparam logic [15:0] DESC_CONFIG = 16'h0200;
	localparam logic [15:0] MAX_ADDRESS = 16'd127;
	localparam logic [15:0] EP0_OUT     = 16'h0000;
	localparam logic [15:0] EP0_IN      = 16'h0080;
	localparam logic [15:0] EP1_OUT     = 16'h0001;
	localparam logic [15:0] EP1_IN      = 16'h0081;
	localparam logic [15:0] LEN_STATUS  = 16'd2;
	localparam logic [15:0] LEN_ONE     = 16'd1;

	typedef enum logic [1:0] {
		ST_UNATTACHED = 2'd0,
		ST_DEFAULT    = 2'd1,
		ST_ADDRESS    = 2'd2,
		ST_CONFIGURED = 2'd3
	} dev_state_t;

	typedef struct packed {
		logic        kind;
		logic [7:0]  request_type;
		logic [7:0]  request_code;
		logic [15:0] setup_value;
		logic [15:0] setup_index;
		logic [15:0] setup_length;
		logic [3:0]  halt_flags;
	} in_item_t;

	typedef struct packed {
		logic [1:0] action;
		logic [1:0] reply_source;
		logic [7:0] reply_length;
		logic       reply_first_byte;
		logic [1:0] current_state;
		logic [6:0] current_address;
		logic [1:0] endpoint_change;
	} out_item_t;

	typedef struct packed {
		logic [7:0] dev_desc_len;
		logic [7:0] cfg_desc_len;
	} cfg_regs_t;

	typedef struct packed {
		dev_state_t state;
		logic [6:0] address;
	} dev_ctx_t;

endpackage

`default_nettype wire

>>> design/usbreq_cfg.sv
// Configuration registers: descriptor lengths written through the plain write port.
// Depends on usbreq_pkg.
`default_nettype none

module usbreq_cfg
	import usbreq_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_write,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_regs_t                  regs
);

	cfg_regs_t regs_q;

	// Capture a write into the addressed register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.dev_desc_len <= DEV_DESC_LEN_RST;
			regs_q.cfg_desc_len <= CFG_DESC_LEN_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_DEV_DESC_LEN: regs_q.dev_desc_len <= cfg_data;
				REG_CFG_DESC_LEN: regs_q.cfg_desc_len <= cfg_data;
				default: ;
			endcase
		end
	end

	assign regs = regs_q;

endmodule

`default_nettype wire

>>> design/usbreq_eval.sv
// Single-pass evaluation of one item: request checks, reply and next device state.
// Depends on usbreq_pkg.
`default_nettype none

module usbreq_eval
	import usbreq_pkg::*;
(
	input  wire in_item_t  item,
	input  wire dev_ctx_t  ctx,
	input  wire cfg_regs_t regs,
	output dev_ctx_t       ctx_next,
	output out_item_t      result
);

	logic [15:0] req;
	logic        set_ok;
	logic        get_ok;
	logic [1:0]  get_src;
	logic [7:0]  get_len;
	logic        get_first;
	logic [7:0]  desc_len;
	logic [7:0]  clip_len;
	logic        is_set;
	logic        is_get;

	assign req    = {item.request_code, item.request_type};
	assign is_set = (item.kind != KIND_BUS_RESET) && (item.setup_length == '0);
	assign is_get = (item.kind != KIND_BUS_RESET) && (item.setup_length != '0)
		&& item.request_type[7];

	// Pick descriptor length and clip to wLength
	always_comb begin
		desc_len = (item.setup_value == DESC_DEVICE) ? regs.dev_desc_len
			: regs.cfg_desc_len;
		clip_len = (item.setup_length < {8'd0, desc_len}) ? item.setup_length[7:0]
			: desc_len;
	end

	// Validate no-data requests
	always_comb begin
		set_ok = 1'b0;
		case (req)
			RQ_SET_ADDRESS:
				set_ok = (ctx.state != ST_CONFIGURED) && (item.setup_value <= MAX_ADDRESS)
					&& (item.setup_index == '0);
			RQ_SET_CONFIG: begin
				if (ctx.state == ST_ADDRESS || ctx.state == ST_CONFIGURED) begin
					set_ok = (item.setup_value == '0) || (item.setup_value == LEN_ONE);
				end
			end
			RQ_SET_INTERFACE:
				set_ok = (ctx.state == ST_CONFIGURED) && (item.setup_index == '0);
			default: set_ok = 1'b0;
		endcase
	end

	// Validate device-to-host requests and build the data reply
	always_comb begin
		get_ok    = 1'b0;
		get_src   = SRC_INLINE;
		get_len   = item.setup_length[7:0];
		get_first = 1'b0;
		case (req)
			RQ_GET_DESCRIPTOR: begin
				get_len = clip_len;
				if (item.setup_index == '0 && clip_len != '0) begin
					if (item.setup_value == DESC_DEVICE) begin
						get_ok  = 1'b1;
						get_src = SRC_DEV;
					end else if (item.setup_value == DESC_CONFIG) begin
						get_ok  = 1'b1;
						get_src = SRC_CFG;
					end
				end
			end
			RQ_GET_STATUS, RQ_GET_STATUS_IF:
				get_ok = (ctx.state != ST_DEFAULT) && (item.setup_value == '0)
					&& (item.setup_index == '0) && (item.setup_length == LEN_STATUS);
			RQ_GET_STATUS_EP: begin
				if (ctx.state != ST_DEFAULT && item.setup_value == '0
						&& item.setup_length == LEN_STATUS) begin
					case (item.setup_index)
						EP0_OUT: begin get_ok = 1'b1; get_first = item.halt_flags[0]; end
						EP0_IN:  begin get_ok = 1'b1; get_first = item.halt_flags[1]; end
						EP1_OUT: begin get_ok = 1'b1; get_first = item.halt_flags[2]; end
						EP1_IN:  begin get_ok = 1'b1; get_first = item.halt_flags[3]; end
						default: get_ok = 1'b0;
					endcase
				end
			end
			RQ_GET_CONFIG: begin
				get_ok    = (ctx.state != ST_DEFAULT) && (item.setup_length == LEN_ONE);
				get_first = (ctx.state == ST_CONFIGURED);
			end
			RQ_GET_INTERFACE:
				get_ok = (ctx.state == ST_CONFIGURED) && (item.setup_length == LEN_ONE);
			default: get_ok = 1'b0;
		endcase
	end

	// Next device state and address
	always_comb begin
		ctx_next = ctx;
		if (item.kind == KIND_BUS_RESET) begin
			ctx_next.state   = ST_DEFAULT;
			ctx_next.address = '0;
		end else if (is_set && set_ok) begin
			case (req)
				RQ_SET_ADDRESS: begin
					ctx_next.address = item.setup_value[6:0];
					ctx_next.state   = (item.setup_value == '0) ? ST_DEFAULT : ST_ADDRESS;
				end
				RQ_SET_CONFIG: begin
					if (ctx.state == ST_ADDRESS && item.setup_value == LEN_ONE) begin
						ctx_next.state = ST_CONFIGURED;
					end else if (ctx.state == ST_CONFIGURED && item.setup_value == '0) begin
						ctx_next.state = ST_ADDRESS;
					end
				end
				default: ;
			endcase
		end
	end

	// Result fields
	always_comb begin
		result                 = '0;
		result.current_state   = ctx_next.state;
		result.current_address = ctx_next.address;
		if (item.kind == KIND_BUS_RESET) begin
			result.action = ACT_NONE;
		end else if (is_set) begin
			result.action = set_ok ? ACT_STATUS : ACT_STALL;
			if (ctx_next.state == ST_CONFIGURED && ctx.state == ST_ADDRESS) begin
				result.endpoint_change = EPC_ENABLE;
			end else if (ctx_next.state == ST_ADDRESS && ctx.state == ST_CONFIGURED) begin
				result.endpoint_change = EPC_DISABLE;
			end
		end else if (is_get && get_ok) begin
			result.action           = ACT_DATA;
			result.reply_source     = get_src;
			result.reply_length     = get_len;
			result.reply_first_byte = get_first;
		end else begin
			result.action = ACT_STALL;
		end
	end

endmodule

`default_nettype wire

>>> design/usb_standard_request_handler.sv
// Device state is updated as each item moves from the input register to the result register.
// Throughput: one item per cycle while out_ready is high or the result register is empty.
// Input is taken while a result waits, as long as the input register is empty or can move on.
// Reset (arst_n low, asynchronous): device unattached, address 0, descriptor lengths 18 and 32,
// both pipeline registers empty.
`default_nettype none

module usb_standard_request_handler
	import usbreq_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_write,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire in_item_t              in_item,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output out_item_t                  out_item
);

	cfg_regs_t regs;
	in_item_t  item_s1;
	logic      valid_s1;
	out_item_t result_s2;
	logic      valid_s2;
	dev_ctx_t  ctx_q;
	dev_ctx_t  ctx_next;
	out_item_t result;
	logic      adv;

	usbreq_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.regs      (regs)
	);

	usbreq_eval u_eval (
		.item     (item_s1),
		.ctx      (ctx_q),
		.regs     (regs),
		.ctx_next (ctx_next),
		.result   (result)
	);

	// Move the held item on when the result register is free or being drained
	assign adv      = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || adv;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

	// Result register and device state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2      <= 1'b0;
			ctx_q.state   <= ST_UNATTACHED;
			ctx_q.address <= '0;
		end else begin
			if (adv) begin
				valid_s2 <= 1'b1;
				ctx_q    <= ctx_next;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			result_s2 <= result;
		end
	end

	assign out_valid = valid_s2;
	assign out_item  = result_s2;

`ifndef SYNTHESIS
	a_reply_fields_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.action != ACT_DATA |->
			out_item.reply_source == SRC_INLINE && out_item.reply_length == '0
			&& !out_item.reply_first_byte)
		else $error("reply fields set without a data reply");

	a_unattached_addr: assert property (@(posedge clk) disable iff (!arst_n)
		ctx_q.state == ST_UNATTACHED |-> ctx_q.address == '0)
		else $error("address set while unattached");

	a_ep_enable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.endpoint_change == EPC_ENABLE |->
			out_item.current_state == ST_CONFIGURED && out_item.action == ACT_STATUS)
		else $error("endpoint enable outside configured state");

	a_ep_disable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.endpoint_change == EPC_DISABLE |->
			out_item.current_state == ST_ADDRESS && out_item.action == ACT_STATUS)
		else $error("endpoint disable outside address state");

	a_ctx_tracks_result: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> out_item.current_state == ctx_q.state
			&& out_item.current_address == ctx_q.address)
		else $error("result state differs from device state");
`endif

endmodule

`default_nettype wire

>>> verif/usb_standard_request_handler_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the endpoint-0 standard request handler.
// Needs usbreq_pkg and usb_standard_request_handler; predicts every reply
// in-line and checks it field by field.

module usb_standard_request_handler_tb;
	import usbreq_pkg::*;

	// Request and endpoint codes outside the standard set
	localparam logic        KIND_SETUP    = ~KIND_BUS_RESET;
	localparam logic [15:0] RQ_VENDOR_OUT = 16'h3340;
	localparam logic [15:0] RQ_VENDOR_IN  = 16'h77C0;
	localparam logic [15:0] DESC_STRING   = 16'h0300;
	localparam logic [15:0] EP_UNKNOWN    = 16'h0002;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_write;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_ready;
	in_item_t              in_item;
	logic                  out_valid;
	logic                  out_ready;
	out_item_t             out_item;

	// Device model state and descriptor lengths
	dev_state_t dev_state;
	logic [6:0] dev_addr;
	logic [7:0] dev_desc_len;
	logic [7:0] cfg_desc_len;

	out_item_t   expected_replies[$];
	int unsigned mismatches = 0;
	bit          quiet = 1'b0;

	usb_standard_request_handler uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item(out_item)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Compute the reply to one item and advance the device model
	function automatic out_item_t predict_reply(input in_item_t it);
		out_item_t   r;
		logic [15:0] req;
		logic [15:0] len;
		logic [15:0] dlen;
		logic [15:0] n;
		logic        ok;
		logic        first;
		r = '0;
		req = {it.request_code, it.request_type};
		len = it.setup_length;
		ok = 1'b0;
		first = 1'b0;
		if (it.kind == KIND_BUS_RESET) begin
			dev_state = ST_DEFAULT;
			dev_addr = '0;
			r.action = ACT_NONE;
		end else if (len != '0 && !it.request_type[7]) begin
			r.action = ACT_STALL;
		end else if (len == '0) begin
			case (req)
				RQ_SET_ADDRESS: begin
					if (dev_state != ST_CONFIGURED && it.setup_value <= MAX_ADDRESS &&
							it.setup_index == '0) begin
						dev_addr = it.setup_value[6:0];
						dev_state = (it.setup_value == '0) ? ST_DEFAULT : ST_ADDRESS;
						ok = 1'b1;
					end
				end
				RQ_SET_CONFIG: begin
					if (dev_state == ST_ADDRESS) begin
						if (it.setup_value == 16'd1) begin
							dev_state = ST_CONFIGURED;
							r.endpoint_change = EPC_ENABLE;
							ok = 1'b1;
						end else begin
							ok = (it.setup_value == '0);
						end
					end else if (dev_state == ST_CONFIGURED) begin
						if (it.setup_value == '0) begin
							dev_state = ST_ADDRESS;
							r.endpoint_change = EPC_DISABLE;
							ok = 1'b1;
						end else begin
							ok = (it.setup_value == 16'd1);
						end
					end
				end
				RQ_SET_INTERFACE: ok = (dev_state == ST_CONFIGURED && it.setup_index == '0);
				default: ok = 1'b0;
			endcase
			r.action = ok ? ACT_STATUS : ACT_STALL;
		end else begin
			r.reply_source = SRC_INLINE;
			r.reply_length = len[7:0];
			case (req)
				RQ_GET_DESCRIPTOR: begin
					dlen = '0;
					if (it.setup_index == '0 && it.setup_value == DESC_DEVICE) begin
						r.reply_source = SRC_DEV;
						dlen = {8'd0, dev_desc_len};
					end else if (it.setup_index == '0 && it.setup_value == DESC_CONFIG) begin
						r.reply_source = SRC_CFG;
						dlen = {8'd0, cfg_desc_len};
					end
					n = (dlen < len) ? dlen : len;
					ok = (n != '0);
					r.reply_length = n[7:0];
				end
				RQ_GET_STATUS, RQ_GET_STATUS_IF: begin
					ok = dev_state != ST_DEFAULT && it.setup_value == '0 &&
						it.setup_index == '0 && len == LEN_STATUS;
				end
				RQ_GET_STATUS_EP: begin
					ok = dev_state != ST_DEFAULT && it.setup_value == '0 && len == LEN_STATUS;
					case (it.setup_index)
						EP0_OUT: first = it.halt_flags[0];
						EP0_IN:  first = it.halt_flags[1];
						EP1_OUT: first = it.halt_flags[2];
						EP1_IN:  first = it.halt_flags[3];
						default: ok = 1'b0;
					endcase
				end
				RQ_GET_CONFIG: begin
					ok = dev_state != ST_DEFAULT && len == LEN_ONE;
					first = (dev_state == ST_CONFIGURED);
				end
				RQ_GET_INTERFACE: ok = (dev_state == ST_CONFIGURED && len == LEN_ONE);
				default: ok = 1'b0;
			endcase
			r.action = ok ? ACT_DATA : ACT_STALL;
			r.reply_first_byte = first;
		end
		// Clear the reply fields on anything but a data reply
		if (r.action != ACT_DATA) begin
			r.reply_source = SRC_INLINE;
			r.reply_length = '0;
			r.reply_first_byte = 1'b0;
		end
		r.current_state = dev_state;
		r.current_address = dev_addr;
		return r;
	endfunction

	function automatic in_item_t setup_req(input logic [15:0] req, input logic [15:0] value,
			input logic [15:0] index, input logic [15:0] length, input logic [3:0] halt);
		in_item_t it;
		it.kind = KIND_SETUP;
		{it.request_code, it.request_type} = req;
		it.setup_value = value;
		it.setup_index = index;
		it.setup_length = length;
		it.halt_flags = halt;
		return it;
	endfunction

	// Mostly well-formed standard requests, with bus resets and raw noise mixed in
	function automatic in_item_t random_request();
		in_item_t    it;
		logic [15:0] req;
		int unsigned pick;
		pick = $urandom_range(0, 99);
		it.kind = KIND_SETUP;
		it.request_type = 8'($urandom_range(0, 255));
		it.request_code = 8'($urandom_range(0, 255));
		it.setup_value = 16'($urandom_range(0, 16'hFFFF));
		it.setup_index = 16'($urandom_range(0, 16'hFFFF));
		it.setup_length = 16'($urandom_range(0, 16'hFFFF));
		it.halt_flags = 4'($urandom_range(0, 15));
		if (pick < 6) begin
			it.kind = KIND_BUS_RESET;
		end else if (pick >= 20) begin
			case ($urandom_range(0, 8))
				0: req = RQ_GET_STATUS;
				1: req = RQ_GET_STATUS_IF;
				2: req = RQ_GET_STATUS_EP;
				3: req = RQ_SET_ADDRESS;
				4: req = RQ_GET_DESCRIPTOR;
				5: req = RQ_GET_CONFIG;
				6: req = RQ_SET_CONFIG;
				7: req = RQ_GET_INTERFACE;
				default: req = RQ_SET_INTERFACE;
			endcase
			{it.request_code, it.request_type} = req;
			it.setup_value = 16'($urandom_range(0, 2));
			it.setup_index = '0;
			it.setup_length = '0;
			case (req)
				RQ_SET_ADDRESS: it.setup_value = 16'($urandom_range(0, 130));
				RQ_GET_DESCRIPTOR: begin
					it.setup_value = $urandom_range(0, 1) ? DESC_DEVICE : DESC_CONFIG;
					it.setup_length = 16'($urandom_range(0, 300));
				end
				RQ_GET_STATUS, RQ_GET_STATUS_IF: begin
					it.setup_value = '0;
					it.setup_length = LEN_STATUS;
				end
				RQ_GET_STATUS_EP: begin
					it.setup_value = '0;
					it.setup_length = LEN_STATUS;
					case ($urandom_range(0, 3))
						0: it.setup_index = EP0_OUT;
						1: it.setup_index = EP0_IN;
						2: it.setup_index = EP1_OUT;
						default: it.setup_index = EP1_IN;
					endcase
				end
				RQ_GET_CONFIG, RQ_GET_INTERFACE: it.setup_length = LEN_ONE;
				default: ;
			endcase
			// Break one field now and then
			case ($urandom_range(0, 11))
				0: it.setup_length = 16'($urandom_range(0, 3));
				1: it.setup_index = 16'($urandom_range(0, 2));
				2: it.setup_value = 16'($urandom_range(0, 16'hFFFF));
				default: ;
			endcase
		end
		return it;
	endfunction

	// Present one item, hold it until accepted, then queue its reply
	task automatic send_item(input in_item_t it);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		in_item <= it;
		in_valid <= 1'b1;
		do @(negedge clk); while (!in_ready);
		@(posedge clk);
		expected_replies.push_back(predict_reply(it));
	endtask

	// Drop valid and wait until every reply is back and the pipeline is empty
	task automatic drain_replies();
		in_valid <= 1'b0;
		while (expected_replies.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_desc_len(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] len);
		drain_replies();
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= len;
		@(posedge clk);
		cfg_write <= 1'b0;
		if (idx == REG_DEV_DESC_LEN)
			dev_desc_len = len;
		else
			cfg_desc_len = len;
	endtask

	// Walk the state machine through every state and request type
	task automatic test_device_states();
		in_item_t bus_reset_item;
		bus_reset_item = '1;
		bus_reset_item.kind = KIND_BUS_RESET;
		send_item(setup_req(RQ_GET_STATUS, '0, '0, LEN_STATUS, 4'h0));
		send_item(setup_req(RQ_SET_ADDRESS, 16'd3, '0, '0, 4'h0));
		send_item(bus_reset_item);
		send_item(setup_req(RQ_GET_CONFIG, '0, '0, LEN_ONE, 4'h0));
		send_item(setup_req(RQ_SET_ADDRESS, 16'd5, '0, 16'd5, 4'h0));
		send_item(setup_req(RQ_VENDOR_OUT, '0, '0, '0, 4'h0));
		send_item(setup_req(RQ_VENDOR_IN, '0, '0, 16'd4, 4'h0));
		send_item(setup_req(RQ_SET_ADDRESS, MAX_ADDRESS + 16'd1, '0, '0, 4'h0));
		send_item(setup_req(RQ_SET_ADDRESS, MAX_ADDRESS, '0, '0, 4'h0));
		send_item(setup_req(RQ_SET_CONFIG, 16'd1, '0, '0, 4'h0));
		send_item(setup_req(RQ_SET_INTERFACE, '0, '0, '0, 4'h0));
		send_item(setup_req(RQ_GET_INTERFACE, '0, '0, LEN_ONE, 4'h0));
		send_item(setup_req(RQ_GET_CONFIG, '0, '0, LEN_ONE, 4'h0));
		send_item(setup_req(RQ_GET_STATUS_EP, '0, EP1_IN, LEN_STATUS, 4'h8));
		send_item(setup_req(RQ_GET_STATUS_EP, '0, EP0_IN, LEN_STATUS, 4'hF));
		send_item(setup_req(RQ_GET_STATUS_EP, '0, EP_UNKNOWN, LEN_STATUS, 4'hF));
		send_item(setup_req(RQ_GET_STATUS_IF, '0, '0, LEN_STATUS, 4'h0));
		send_item(setup_req(RQ_SET_ADDRESS, 16'd9, '0, '0, 4'h0));
		send_item(setup_req(RQ_SET_CONFIG, '0, '0, '0, 4'h0));
		send_item(setup_req(RQ_GET_DESCRIPTOR, DESC_STRING, '0, 16'd8, 4'h0));
		send_item(setup_req(RQ_SET_ADDRESS, '0, '0, '0, 4'h0));
	endtask

	// Clip descriptor replies against extreme register settings
	task automatic test_descriptor_lengths();
		write_desc_len(REG_DEV_DESC_LEN, 8'd0);
		write_desc_len(REG_CFG_DESC_LEN, 8'd255);
		send_item(setup_req(RQ_GET_DESCRIPTOR, DESC_DEVICE, '0, 16'd64, 4'h0));
		send_item(setup_req(RQ_GET_DESCRIPTOR, DESC_CONFIG, '0, 16'hFFFF, 4'h0));
		send_item(setup_req(RQ_GET_DESCRIPTOR, DESC_CONFIG, '0, '0, 4'h0));
		write_desc_len(REG_DEV_DESC_LEN, 8'd255);
		write_desc_len(REG_CFG_DESC_LEN, 8'd1);
		send_item(setup_req(RQ_GET_DESCRIPTOR, DESC_DEVICE, '0, 16'hFFFF, 4'h0));
		send_item(setup_req(RQ_GET_DESCRIPTOR, DESC_CONFIG, 16'd1, 16'd2, 4'h0));
		send_item(setup_req(RQ_GET_DESCRIPTOR, DESC_CONFIG, '0, 16'd2, 4'h0));
		write_desc_len(REG_DEV_DESC_LEN, DEV_DESC_LEN_RST);
		write_desc_len(REG_CFG_DESC_LEN, CFG_DESC_LEN_RST);
	endtask

	// Random traffic with a drain and a register change halfway, no idling at the end
	task automatic test_random_traffic();
		for (int i = 0; i < 450; i++) begin
			if (i == 225) begin
				write_desc_len(REG_DEV_DESC_LEN, 8'($urandom_range(0, 255)));
				write_desc_len(REG_CFG_DESC_LEN, 8'($urandom_range(0, 255)));
			end
			if (i == 390)
				quiet = 1'b1;
			send_item(random_request());
		end
	endtask

	// Result side: stall in random bursts
	initial begin
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (!quiet && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 10)) @(posedge clk);
			end
			out_ready <= 1'b1;
			repeat ($urandom_range(0, 8)) @(posedge clk);
		end
	end

	function automatic void compare_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	// Sample between edges; the item moves at the next rising edge
	always @(negedge clk) begin : check_replies
		out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_replies.size() == 0) begin
				$error("unexpected result item: %p", out_item);
				mismatches++;
			end else begin
				want = expected_replies.pop_front();
				compare_field("action", 32'(want.action), 32'(out_item.action));
				compare_field("reply_source", 32'(want.reply_source),
					32'(out_item.reply_source));
				compare_field("reply_length", 32'(want.reply_length),
					32'(out_item.reply_length));
				compare_field("reply_first_byte", 32'(want.reply_first_byte),
					32'(out_item.reply_first_byte));
				compare_field("current_state", 32'(want.current_state),
					32'(out_item.current_state));
				compare_field("current_address", 32'(want.current_address),
					32'(out_item.current_address));
				compare_field("endpoint_change", 32'(want.endpoint_change),
					32'(out_item.endpoint_change));
			end
		end
	end

	initial begin
		#5_000_000;
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		dev_state = ST_UNATTACHED;
		dev_addr = '0;
		dev_desc_len = DEV_DESC_LEN_RST;
		cfg_desc_len = CFG_DESC_LEN_RST;
		arst_n <= 1'b0;
		cfg_write <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		in_valid <= 1'b0;
		in_item <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_device_states();
		test_descriptor_lengths();
		test_random_traffic();
		drain_replies();
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
